/* src/btr_pkg.sv */
`timescale 1ns / 1ps

package btr_pkg;

  localparam int DEF_MAX_WIDTH     = 256;
  localparam int DEF_MAX_HEIGHT    = 256;
  localparam int DEF_SUBPIXEL_BITS = 4;

  localparam int MODE_W    = 2;
  localparam int VERT_W    = 16;
  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 8;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  localparam int CW     = VERT_W + 1;
  localparam int DIFF_W = VERT_W + 2;
  localparam int OPW    = 24;
  localparam int EW     = 2 * OPW;

  localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'hFF;

  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef struct packed {
    logic                 skip;
    logic signed [CW-1:0] xmin;
    logic signed [CW-1:0] xmax;
    logic signed [CW-1:0] ymin;
    logic signed [CW-1:0] ymax;
    logic signed [EW-1:0] area;
    logic signed [EW-1:0] e0;
    logic signed [EW-1:0] e1;
    logic signed [EW-1:0] dx0;
    logic signed [EW-1:0] dx1;
    logic signed [EW-1:0] dy0;
    logic signed [EW-1:0] dy1;
  } setup_t;

endpackage

/* src/btr_ifs.sv */
`timescale 1ns / 1ps

interface btr_req_if;
  import btr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VERT_W-1:0]  vert0_x;
  logic signed [VERT_W-1:0]  vert0_y;
  logic signed [VERT_W-1:0]  vert1_x;
  logic signed [VERT_W-1:0]  vert1_y;
  logic signed [VERT_W-1:0]  vert2_x;
  logic signed [VERT_W-1:0]  vert2_y;
  logic [COLOR_W-1:0]        color0;
  logic [COLOR_W-1:0]        color1;
  logic [COLOR_W-1:0]        color2;
  logic [PIX_W-1:0]          pixel_x;
  logic [PIX_W-1:0]          pixel_y;
  modport source (output valid, mode, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                  color0, color1, color2, pixel_x, pixel_y, input ready);
  modport sink (input valid, mode, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                color0, color1, color2, pixel_x, pixel_y, output ready);
endinterface

interface btr_rsp_if;
  import btr_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] pixel_word;
  modport source (output valid, pixel_word, input ready);
  modport sink (input valid, pixel_word, output ready);
endinterface

interface btr_cfg_if;
  import btr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/btr_fmem.sv */
`timescale 1ns / 1ps

module btr_fmem #(
  parameter int DEPTH  = btr_pkg::DEF_MAX_WIDTH * btr_pkg::DEF_MAX_HEIGHT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [btr_pkg::WORD_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [btr_pkg::WORD_W-1:0] rdata_o
);
  import btr_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/btr_setup.sv */
`timescale 1ns / 1ps

module btr_setup #(
  parameter int MAX_WIDTH     = btr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = btr_pkg::DEF_MAX_HEIGHT,
  parameter int SUBPIXEL_BITS = btr_pkg::DEF_SUBPIXEL_BITS,
  parameter int DWW           = $clog2(MAX_WIDTH + 1),
  parameter int DWH           = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [btr_pkg::VERT_W-1:0] vert0_x_i,
  input  logic signed [btr_pkg::VERT_W-1:0] vert0_y_i,
  input  logic signed [btr_pkg::VERT_W-1:0] vert1_x_i,
  input  logic signed [btr_pkg::VERT_W-1:0] vert1_y_i,
  input  logic signed [btr_pkg::VERT_W-1:0] vert2_x_i,
  input  logic signed [btr_pkg::VERT_W-1:0] vert2_y_i,
  input  logic [DWW-1:0]                    aw_i,
  input  logic [DWH-1:0]                    ah_i,
  output logic                              done_o,
  output btr_pkg::setup_t                   setup_o
);
  import btr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_FIN} state_e;

  function automatic logic signed [VERT_W-1:0] min3(input logic signed [VERT_W-1:0] a,
                                                    input logic signed [VERT_W-1:0] b,
                                                    input logic signed [VERT_W-1:0] c);
    logic signed [VERT_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [VERT_W-1:0] max3(input logic signed [VERT_W-1:0] a,
                                                    input logic signed [VERT_W-1:0] b,
                                                    input logic signed [VERT_W-1:0] c);
    logic signed [VERT_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  state_e       state_q;
  logic [2:0]   cnt_q;
  logic         done_q;

  logic signed [CW-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [CW-1:0] xmin_r, ymin_r, xmax_r, ymax_r;
  logic signed [CW-1:0] xmin_c, ymin_c, xmax_c, ymax_c, lim_x, lim_y;

  logic signed [DIFF_W-1:0] a0_q, b0_q, a1_q, b1_q;
  logic signed [CW-1:0]     x0_q, y0_q, x2_q, y2_q;
  logic signed [CW-1:0]     xmin_q, xmax_q, ymin_q, ymax_q;
  logic                     skip_q;
  logic signed [EW-1:0]     p_q, acc_q, area_q, e0_q, e1_q;
  logic signed [EW-1:0]     dx0_q, dx1_q, dy0_q, dy1_q;

  logic signed [OPW-1:0] pxmin, pymin, op_a, op_b;
  logic signed [EW-1:0]  prod;
  logic [2:0]            j;

  assign x0 = $signed({vert0_x_i, 1'b0});
  assign y0 = $signed({vert0_y_i, 1'b0});
  assign x1 = $signed({vert1_x_i, 1'b0});
  assign y1 = $signed({vert1_y_i, 1'b0});
  assign x2 = $signed({vert2_x_i, 1'b0});
  assign y2 = $signed({vert2_y_i, 1'b0});

  assign xmin_r = CW'(min3(vert0_x_i, vert1_x_i, vert2_x_i)) >>> SUBPIXEL_BITS;
  assign ymin_r = CW'(min3(vert0_y_i, vert1_y_i, vert2_y_i)) >>> SUBPIXEL_BITS;
  assign xmax_r = (CW'(max3(vert0_x_i, vert1_x_i, vert2_x_i)) +
                   CW'((1 << SUBPIXEL_BITS) - 1)) >>> SUBPIXEL_BITS;
  assign ymax_r = (CW'(max3(vert0_y_i, vert1_y_i, vert2_y_i)) +
                   CW'((1 << SUBPIXEL_BITS) - 1)) >>> SUBPIXEL_BITS;

  assign lim_x  = $signed(CW'({1'b0, aw_i})) - CW'(1);
  assign lim_y  = $signed(CW'({1'b0, ah_i})) - CW'(1);
  assign xmin_c = (xmin_r < 0) ? '0 : xmin_r;
  assign ymin_c = (ymin_r < 0) ? '0 : ymin_r;
  assign xmax_c = (xmax_r > lim_x) ? lim_x : xmax_r;
  assign ymax_c = (ymax_r > lim_y) ? lim_y : ymax_r;

  assign pxmin = ((OPW'(xmin_q) <<< 1) + OPW'(1)) <<< SUBPIXEL_BITS;
  assign pymin = ((OPW'(ymin_q) <<< 1) + OPW'(1)) <<< SUBPIXEL_BITS;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cnt_q)
      3'd0: begin
        op_a = OPW'(a0_q);
        op_b = OPW'(b1_q);
      end
      3'd1: begin
        op_a = OPW'(b0_q);
        op_b = OPW'(a1_q);
      end
      3'd2: begin
        op_a = OPW'(a0_q);
        op_b = pxmin - OPW'(x2_q);
      end
      3'd3: begin
        op_a = OPW'(b0_q);
        op_b = pymin - OPW'(y2_q);
      end
      3'd4: begin
        op_a = OPW'(a1_q);
        op_b = pxmin - OPW'(x0_q);
      end
      3'd5: begin
        op_a = OPW'(b1_q);
        op_b = pymin - OPW'(y0_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;
  assign j    = cnt_q - 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd6) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      a0_q   <= DIFF_W'(y1) - DIFF_W'(y2);
      b0_q   <= DIFF_W'(x2) - DIFF_W'(x1);
      a1_q   <= DIFF_W'(y2) - DIFF_W'(y0);
      b1_q   <= DIFF_W'(x0) - DIFF_W'(x2);
      x0_q   <= x0;
      y0_q   <= y0;
      x2_q   <= x2;
      y2_q   <= y2;
      xmin_q <= xmin_c;
      ymin_q <= ymin_c;
      xmax_q <= xmax_c;
      ymax_q <= ymax_c;
      skip_q <= (xmin_c > xmax_c) || (ymin_c > ymax_c);
    end
    if (state_q == S_MUL) begin
      if (cnt_q != 3'd6) begin
        p_q <= prod;
      end
      if (cnt_q != 3'd0) begin
        case (j)
          3'd0: acc_q <= p_q;
          3'd1: area_q <= acc_q - p_q;
          3'd2: acc_q <= p_q;
          3'd3: e0_q <= acc_q + p_q;
          3'd4: acc_q <= p_q;
          3'd5: e1_q <= acc_q + p_q;
          default: acc_q <= acc_q;
        endcase
      end
      if (cnt_q == 3'd0) begin
        dx0_q <= EW'(a0_q) <<< (SUBPIXEL_BITS + 1);
        dx1_q <= EW'(a1_q) <<< (SUBPIXEL_BITS + 1);
        dy0_q <= EW'(b0_q) <<< (SUBPIXEL_BITS + 1);
        dy1_q <= EW'(b1_q) <<< (SUBPIXEL_BITS + 1);
      end
    end
    if (state_q == S_FIN && area_q < 0) begin
      area_q <= -area_q;
      e0_q   <= -e0_q;
      e1_q   <= -e1_q;
      dx0_q  <= -dx0_q;
      dx1_q  <= -dx1_q;
      dy0_q  <= -dy0_q;
      dy1_q  <= -dy1_q;
    end
  end

  assign done_o        = done_q;
  assign setup_o.skip  = skip_q;
  assign setup_o.xmin  = xmin_q;
  assign setup_o.xmax  = xmax_q;
  assign setup_o.ymin  = ymin_q;
  assign setup_o.ymax  = ymax_q;
  assign setup_o.area  = area_q;
  assign setup_o.e0    = e0_q;
  assign setup_o.e1    = e1_q;
  assign setup_o.dx0   = dx0_q;
  assign setup_o.dx1   = dx1_q;
  assign setup_o.dy0   = dy0_q;
  assign setup_o.dy1   = dy1_q;

endmodule

/* src/btr_shade.sv */
`timescale 1ns / 1ps

module btr_shade (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [btr_pkg::EW-1:0]      e0_i,
  input  logic signed [btr_pkg::EW-1:0]      e1_i,
  input  logic signed [btr_pkg::EW-1:0]      e2_i,
  input  logic signed [btr_pkg::EW-1:0]      area_i,
  input  logic [btr_pkg::COLOR_W-1:0]        color0_i,
  input  logic [btr_pkg::COLOR_W-1:0]        color1_i,
  input  logic [btr_pkg::COLOR_W-1:0]        color2_i,
  output logic                               done_o,
  output logic [btr_pkg::COLOR_W-1:0]        rgb_o
);
  import btr_pkg::*;

  localparam int PW = EW - 1 + CHAN_W;
  localparam int DW = EW - 1 + 7;
  localparam int RW = EW + 9;

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_DIV} state_e;

  state_e     state_q;
  logic [2:0] cnt_q;
  logic       done_q;

  logic [PW-1:0]     p_q [3][3];
  logic [RW-1:0]     rem_q [3];
  logic [CHAN_W-1:0] quo_q [3];
  logic [EW-2:0]     ev [3];
  logic [CHAN_W-1:0] cv [3][3];
  logic [DW-1:0]     dvs;

  assign ev[0] = e0_i[EW-2:0];
  assign ev[1] = e1_i[EW-2:0];
  assign ev[2] = e2_i[EW-2:0];
  assign dvs   = DW'(area_i[EW-2:0]) << 7;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign cv[c][0] = color0_i[CHAN_W*c +: CHAN_W];
    assign cv[c][1] = color1_i[CHAN_W*c +: CHAN_W];
    assign cv[c][2] = color2_i[CHAN_W*c +: CHAN_W];
    assign rgb_o[CHAN_W*c +: CHAN_W] = quo_q[c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          state_q <= S_DIV;
          cnt_q   <= '0;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (state_q == S_IDLE && start_i) begin
        for (int v = 0; v < 3; v++) begin
          p_q[c][v] <= PW'(ev[v]) * PW'(cv[c][v]);
        end
      end
      if (state_q == S_SUM) begin
        rem_q[c] <= RW'(p_q[c][0]) + RW'(p_q[c][1]) + RW'(p_q[c][2]);
      end
      if (state_q == S_DIV) begin
        if (rem_q[c] >= RW'(dvs)) begin
          rem_q[c] <= (rem_q[c] - RW'(dvs)) << 1;
          quo_q[c] <= {quo_q[c][CHAN_W-2:0], 1'b1};
        end else begin
          rem_q[c] <= rem_q[c] << 1;
          quo_q[c] <= {quo_q[c][CHAN_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done_o = done_q;

endmodule

/* src/barycentric_triangle_raster.sv */
`timescale 1ns / 1ps

// Channel  Port   Direction  Carries
// request  req_i  in         mode, three vertices, three colors, pixel address
// result   rsp_o  out        pixel_word, one per read request
// config   cfg_i  in         index 0 active_width, index 1 active_height
//
// Draw: setup, then for each pixel of the clipped box an edge test, and if covered
//   also product, sum, 8 restoring divide steps and write.
// Clear: one cycle per active pixel, one frame store write port.
// Read: registered frame store read, then any wait on the result register. Frame
//   store is not cleared by reset; config registers reset to MAX_WIDTH and MAX_HEIGHT.
// A request is taken only between operations; a held result does not stall draw or clear.

module barycentric_triangle_raster #(
  parameter int MAX_WIDTH     = btr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = btr_pkg::DEF_MAX_HEIGHT,
  parameter int SUBPIXEL_BITS = btr_pkg::DEF_SUBPIXEL_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  btr_req_if.sink   req_i,
  btr_rsp_if.source rsp_o,
  btr_cfg_if.sink   cfg_i
);
  import btr_pkg::*;

  localparam int DWW    = $clog2(MAX_WIDTH + 1);
  localparam int DWH    = $clog2(MAX_HEIGHT + 1);
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_TEST, S_SHADE, S_CLEAR, S_RDREQ, S_RDOUT}
    state_e;

  state_e           state_q;
  logic [DWW-1:0]   aw_q;
  logic [DWH-1:0]   ah_q;
  logic [XW-1:0]    x_q;
  logic [YW-1:0]    y_q;
  logic signed [EW-1:0] e0_q, e1_q, e0r_q, e1r_q;
  logic [COLOR_W-1:0]   col0_q, col1_q, col2_q;
  logic [XW-1:0]        rx_q;
  logic [YW-1:0]        ry_q;
  logic                 oor_q;
  logic                 ovalid_q;
  logic [WORD_W-1:0]    oword_q;

  logic                 accept;
  logic                 setup_done;
  setup_t               setup;
  logic signed [EW-1:0] e2;
  logic                 covered;
  logic                 shade_done;
  logic [COLOR_W-1:0]   rgb;
  logic                 last_x, last_y, clr_last_x, clr_last_y;
  logic                 we;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [WORD_W-1:0]    wdata, rdata;
  logic                 out_free;

  assign accept   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free = !ovalid_q || rsp_o.ready;

  assign e2      = setup.area - e0_q - e1_q;
  assign covered = !e0_q[EW-1] && !e1_q[EW-1] && !e2[EW-1];

  assign last_x     = (x_q == setup.xmax[XW-1:0]);
  assign last_y     = (y_q == setup.ymax[YW-1:0]);
  assign clr_last_x = (DWW'(x_q) == aw_q - DWW'(1));
  assign clr_last_y = (DWH'(y_q) == ah_q - DWH'(1));

  assign we    = (state_q == S_SHADE && shade_done) || (state_q == S_CLEAR);
  assign waddr = ADDR_W'(y_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q);
  assign wdata = (state_q == S_CLEAR) ? {ALPHA_FULL, col0_q} : {ALPHA_FULL, rgb};
  assign raddr = ADDR_W'(ry_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rx_q);

  btr_setup #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .SUBPIXEL_BITS(SUBPIXEL_BITS),
    .DWW          (DWW),
    .DWH          (DWH)
  ) u_setup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && req_i.mode == MODE_DRAW),
    .vert0_x_i(req_i.vert0_x),
    .vert0_y_i(req_i.vert0_y),
    .vert1_x_i(req_i.vert1_x),
    .vert1_y_i(req_i.vert1_y),
    .vert2_x_i(req_i.vert2_x),
    .vert2_y_i(req_i.vert2_y),
    .aw_i     (aw_q),
    .ah_i     (ah_q),
    .done_o   (setup_done),
    .setup_o  (setup)
  );

  btr_shade u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_TEST && covered),
    .e0_i    (e0_q),
    .e1_i    (e1_q),
    .e2_i    (e2),
    .area_i  (setup.area),
    .color0_i(col0_q),
    .color1_i(col1_q),
    .color2_i(col2_q),
    .done_o  (shade_done),
    .rgb_o   (rgb)
  );

  btr_fmem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_fmem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (state_q == S_RDREQ),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= DWW'(MAX_WIDTH);
      ah_q <= DWH'(MAX_HEIGHT);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_WIDTH: begin
          if (cfg_i.data == '0) begin
            aw_q <= DWW'(1);
          end else if (32'(cfg_i.data) > 32'(MAX_WIDTH)) begin
            aw_q <= DWW'(MAX_WIDTH);
          end else begin
            aw_q <= DWW'(cfg_i.data);
          end
        end
        CFG_HEIGHT: begin
          if (cfg_i.data == '0) begin
            ah_q <= DWH'(1);
          end else if (32'(cfg_i.data) > 32'(MAX_HEIGHT)) begin
            ah_q <= DWH'(MAX_HEIGHT);
          end else begin
            ah_q <= DWH'(cfg_i.data);
          end
        end
        default: begin
          aw_q <= aw_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (rsp_o.valid && rsp_o.ready && !(state_q == S_RDOUT && out_free)) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req_i.mode)
              MODE_DRAW:  state_q <= S_SETUP;
              MODE_CLEAR: state_q <= S_CLEAR;
              MODE_READ:  state_q <= S_RDREQ;
              default:    state_q <= S_IDLE;
            endcase
          end
        end
        S_SETUP: begin
          if (setup_done) begin
            if (setup.skip || setup.area == '0) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (covered) begin
            state_q <= S_SHADE;
          end else if (last_x && last_y) begin
            state_q <= S_IDLE;
          end
        end
        S_SHADE: begin
          if (shade_done) begin
            state_q <= (last_x && last_y) ? S_IDLE : S_TEST;
          end
        end
        S_CLEAR: begin
          if (clr_last_x && clr_last_y) begin
            state_q <= S_IDLE;
          end
        end
        S_RDREQ: begin
          state_q <= S_RDOUT;
        end
        S_RDOUT: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col0_q <= req_i.color0;
      col1_q <= req_i.color1;
      col2_q <= req_i.color2;
      rx_q   <= XW'(req_i.pixel_x);
      ry_q   <= YW'(req_i.pixel_y);
      oor_q  <= (32'(req_i.pixel_x) >= 32'(MAX_WIDTH)) ||
                (32'(req_i.pixel_y) >= 32'(MAX_HEIGHT));
      x_q    <= '0;
      y_q    <= '0;
    end
    if (state_q == S_SETUP && setup_done) begin
      x_q   <= setup.xmin[XW-1:0];
      y_q   <= setup.ymin[YW-1:0];
      e0_q  <= setup.e0;
      e1_q  <= setup.e1;
      e0r_q <= setup.e0;
      e1r_q <= setup.e1;
    end
    if ((state_q == S_TEST && !covered) || (state_q == S_SHADE && shade_done)) begin
      if (last_x) begin
        x_q   <= setup.xmin[XW-1:0];
        y_q   <= y_q + YW'(1);
        e0r_q <= e0r_q + setup.dy0;
        e1r_q <= e1r_q + setup.dy1;
        e0_q  <= e0r_q + setup.dy0;
        e1_q  <= e1r_q + setup.dy1;
      end else begin
        x_q  <= x_q + XW'(1);
        e0_q <= e0_q + setup.dx0;
        e1_q <= e1_q + setup.dx1;
      end
    end
    if (state_q == S_CLEAR) begin
      if (clr_last_x) begin
        x_q <= '0;
        y_q <= y_q + YW'(1);
      end else begin
        x_q <= x_q + XW'(1);
      end
    end
    if (state_q == S_RDOUT && out_free) begin
      oword_q <= oor_q ? '0 : rdata;
    end
  end

  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.pixel_word = oword_q;

endmodule
